@@ hw/rtl/tccw_pkg.sv @@
// shared constants and types of the text console cell writer
`timescale 1ns / 1ps

package tccw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int POS_W  = 11;

  // character and attribute codes
  localparam logic [7:0] NEWLINE_CODE = 8'h0a;
  localparam logic [7:0] BLANK_GLYPH  = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h1f;

  // command queue depth
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // classified item from the front end
  typedef struct packed {
    logic       is_glyph;
    logic [7:0] glyph;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [POS_W-1:0] cursor_pos;
    logic             cell_written;
    logic [POS_W-1:0] written_addr;
    logic             did_scroll;
  } res_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY,
    ST_FILL
  } back_state_e;

endpackage

@@ hw/rtl/tccw_front.sv @@
// input stage: accepts character items and classifies them
`timescale 1ns / 1ps

module tccw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [7:0]          char_code_i,
  input  logic                clearing_i,
  input  logic                q_full_i,
  output logic                full_o,
  output logic                cmd_valid_o,
  output tccw_pkg::cmd_t      cmd_o
);

  logic           valid_d, valid_q;
  tccw_pkg::cmd_t cmd_d, cmd_q;
  logic           accept;
  logic           handoff;

  // handshake towards the input side and the queue
  assign handoff = valid_q & ~q_full_i;
  assign full_o  = (valid_q & q_full_i) | clearing_i;
  assign accept  = push_i & ~full_o;

  // classify the incoming byte
  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (handoff) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d        = 1'b1;
      cmd_d.is_glyph = (char_code_i != tccw_pkg::NEWLINE_CODE);
      cmd_d.glyph    = char_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

@@ hw/rtl/tccw_cmd_queue.sv @@
// short command queue between the front end and the back end
`timescale 1ns / 1ps

module tccw_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  input  tccw_pkg::cmd_t wr_cmd_i,
  output logic           full_o,
  output logic           rd_valid_o,
  output tccw_pkg::cmd_t rd_cmd_o,
  input  logic           rd_pop_i
);

  tccw_pkg::cmd_t                 entries_q [tccw_pkg::QDEPTH];
  logic [tccw_pkg::QPTR_W-1:0]    wr_ptr_d, wr_ptr_q;
  logic [tccw_pkg::QPTR_W-1:0]    rd_ptr_d, rd_ptr_q;
  logic [tccw_pkg::QCNT_W-1:0]    count_d, count_q;
  logic                           do_wr, do_rd;

  assign full_o     = (count_q == tccw_pkg::QCNT_W'(tccw_pkg::QDEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_cmd_o   = entries_q[rd_ptr_q];
  assign do_wr      = wr_valid_i & ~full_o;
  assign do_rd      = rd_pop_i & rd_valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

@@ hw/rtl/tccw_back.sv @@
// back end: cursor, screen store, scroll and clear sequencer, result register
`timescale 1ns / 1ps

module tccw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic [7:0]     cfg_data_i,
  input  logic           cmd_valid_i,
  input  tccw_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           clearing_o,
  output logic           res_valid_o,
  output tccw_pkg::res_t res_o,
  input  logic           res_pop_i
);

  localparam int ADDR_W = tccw_pkg::ADDR_W;
  localparam int COL_W  = tccw_pkg::COL_W;
  localparam int ROW_W  = tccw_pkg::ROW_W;
  localparam int POS_W  = tccw_pkg::POS_W;

  tccw_pkg::back_state_e state_d, state_q;

  logic [7:0]        attr_q;
  logic [COL_W-1:0]  col_d, col_q;
  logic [ROW_W-1:0]  row_d, row_q;
  logic [ADDR_W-1:0] ptr_d, ptr_q;
  logic              pend_d, pend_q;
  logic [ADDR_W-1:0] dst_d, dst_q;
  logic              res_valid_d, res_valid_q;
  tccw_pkg::res_t    res_d, res_q;

  logic [15:0]       mem [tccw_pkg::CELLS];
  logic [15:0]       rd_data_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;

  logic              take;
  logic              wrap;
  logic              scroll;
  logic [COL_W:0]    col_inc;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] new_addr;

  // attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tccw_pkg::RESET_ATTR;
    end else if (cfg_valid_i) begin
      attr_q <= cfg_data_i;
    end
  end

  // a command is taken when idle and the result slot frees up
  assign take      = (state_q == tccw_pkg::ST_IDLE) & cmd_valid_i & (~res_valid_q | res_pop_i);
  assign cmd_pop_o = take;

  // cursor arithmetic
  assign cur_addr = ADDR_W'(row_q) * ADDR_W'(tccw_pkg::COLUMNS) + ADDR_W'(col_q);
  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign wrap     = ~cmd_i.is_glyph | (col_inc == (COL_W + 1)'(tccw_pkg::COLUMNS));
  assign scroll   = wrap & (row_q == ROW_W'(tccw_pkg::ROWS - 1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (take) begin
      if (wrap) begin
        col_d = '0;
        if (!scroll) begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_inc[COL_W-1:0];
      end
    end
  end

  assign new_addr = ADDR_W'(row_d) * ADDR_W'(tccw_pkg::COLUMNS) + ADDR_W'(col_d);

  // result register
  always_comb begin
    res_valid_d = res_valid_q;
    res_d       = res_q;
    if (take) begin
      res_valid_d        = 1'b1;
      res_d.cursor_pos   = POS_W'(new_addr);
      res_d.cell_written = cmd_i.is_glyph;
      res_d.written_addr = cmd_i.is_glyph ? POS_W'(cur_addr) : '0;
      res_d.did_scroll   = scroll;
    end else if (res_pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tccw_pkg::ST_CLEAR: begin
        if (ptr_q == ADDR_W'(tccw_pkg::CELLS - 1)) begin
          state_d = tccw_pkg::ST_IDLE;
        end
      end
      tccw_pkg::ST_IDLE: begin
        if (take && scroll) begin
          state_d = tccw_pkg::ST_COPY;
        end
      end
      tccw_pkg::ST_COPY: begin
        if (ptr_q == ADDR_W'(tccw_pkg::CELLS - 1)) begin
          state_d = tccw_pkg::ST_FILL;
        end
      end
      tccw_pkg::ST_FILL: begin
        if (!pend_q && ptr_q == ADDR_W'(tccw_pkg::CELLS - 1)) begin
          state_d = tccw_pkg::ST_IDLE;
        end
      end
      default: state_d = tccw_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: pointer, copy pipeline and store write port
  always_comb begin
    ptr_d     = ptr_q;
    pend_d    = 1'b0;
    dst_d     = dst_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = {attr_q, tccw_pkg::BLANK_GLYPH};
    unique case (state_q)
      tccw_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {tccw_pkg::RESET_ATTR, tccw_pkg::BLANK_GLYPH};
        ptr_d     = ptr_q + 1'b1;
      end
      tccw_pkg::ST_IDLE: begin
        ptr_d = ADDR_W'(tccw_pkg::COLUMNS);
        if (take && cmd_i.is_glyph) begin
          mem_we    = 1'b1;
          mem_waddr = cur_addr;
          mem_wdata = {attr_q, cmd_i.glyph};
        end
      end
      tccw_pkg::ST_COPY: begin
        // read one row down, write it back one row up in the next cycle
        mem_re = 1'b1;
        pend_d = 1'b1;
        dst_d  = ptr_q - ADDR_W'(tccw_pkg::COLUMNS);
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = dst_q;
          mem_wdata = rd_data_q;
        end
        if (ptr_q == ADDR_W'(tccw_pkg::CELLS - 1)) begin
          ptr_d = ADDR_W'(tccw_pkg::CELLS - tccw_pkg::COLUMNS);
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      tccw_pkg::ST_FILL: begin
        mem_we = 1'b1;
        if (pend_q) begin
          // last copied cell goes out before the blank row
          mem_waddr = dst_q;
          mem_wdata = rd_data_q;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tccw_pkg::ST_CLEAR;
      col_q       <= '0;
      row_q       <= '0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_q <= dst_d;
    res_q <= res_d;
  end

  // screen store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[ptr_q];
    end
  end

  assign clearing_o  = (state_q == tccw_pkg::ST_CLEAR);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ hw/rtl/text_console_cell_writer.sv @@
// top level of the text console cell writer
`timescale 1ns / 1ps

// Text console writer for an 80 x 25 screen of 16-bit cells (glyph in the low
// byte, attribute in the high byte). Push one byte per item: 10 is a newline,
// anything else is a glyph stored at the cursor with the current attribute.
// Every item gives one result with the new linear cursor position, whether
// and where a cell was written, and whether the screen scrolled. Items pass
// an input register and a four-entry command queue; the back end then takes
// one item per cycle while results are popped. A scroll holds the back end
// while it copies rows up through the store, one read and one write a
// cycle, then blanks the bottom row; the queue keeps taking items until it
// fills.
// After reset a clearing pass writes blanks with attribute 0x1f into the
// store, and full stays high for that time. The attribute register may be
// written at any time the block is idle; cfg_ready is always high.
module text_console_cell_writer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // character items
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 char_code_i,
  // result items
  output logic                       empty,
  input  logic                       pop,
  output logic [tccw_pkg::POS_W-1:0] cursor_pos_o,
  output logic                       cell_written_o,
  output logic [tccw_pkg::POS_W-1:0] written_addr_o,
  output logic                       did_scroll_o,
  // attribute register write
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [7:0]                 cfg_data_i
);

  logic           clearing;
  logic           q_full;
  logic           front_valid;
  tccw_pkg::cmd_t front_cmd;
  logic           q_valid;
  tccw_pkg::cmd_t q_cmd;
  logic           q_pop;
  logic           res_valid;
  tccw_pkg::res_t res;

  // accept and classify
  tccw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .char_code_i (char_code_i),
    .clearing_i  (clearing),
    .q_full_i    (q_full),
    .full_o      (full),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  // decoupling queue
  tccw_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_cmd_i   (front_cmd),
    .full_o     (q_full),
    .rd_valid_o (q_valid),
    .rd_cmd_o   (q_cmd),
    .rd_pop_i   (q_pop)
  );

  // carry out commands on the screen store
  tccw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .clearing_o  (clearing),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  // result ports
  assign empty          = ~res_valid;
  assign cursor_pos_o   = res.cursor_pos;
  assign cell_written_o = res.cell_written;
  assign written_addr_o = res.written_addr;
  assign did_scroll_o   = res.did_scroll;
  assign cfg_ready_o    = 1'b1;

endmodule

@@ sim/tb_top.sv @@
// testbench for the text console cell writer: queue driver, predictor and result checker
`timescale 1ns / 1ps

module tb_top;
  import tccw_pkg::*;

  // wait budget for a scroll in the back end, with some margin
  localparam int SCROLL_CYCLES = 2100;
  localparam int HOLD_CYCLES   = 500;

  logic             clk_i;
  logic             rst_ni;
  logic             push;
  logic             full;
  logic [7:0]       char_code_i;
  logic             empty;
  logic             pop;
  logic [POS_W-1:0] cursor_pos_o;
  logic             cell_written_o;
  logic [POS_W-1:0] written_addr_o;
  logic             did_scroll_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [7:0]       cfg_data_i;

  // pending characters and predicted cursor results
  logic [7:0] char_q[$];
  res_t       cursor_results[$];

  // predictor state
  logic [15:0]      screen_model [CELLS];
  logic [COL_W-1:0] col_model;
  logic [ROW_W-1:0] row_model;
  logic [7:0]       attr_model;

  // run control and statistics
  bit     took;
  bit     no_idle;
  bit     hold_done;
  int     send_gap, send_calm;
  int     pop_gap, pop_calm, hold_cnt;
  int     errors;
  int     results_seen;
  int     glyph_count, newline_count, wrap_count, scroll_count, attr_writes;
  longint cycle_count, cycle_limit;

  text_console_cell_writer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .char_code_i    (char_code_i),
    .empty          (empty),
    .pop            (pop),
    .cursor_pos_o   (cursor_pos_o),
    .cell_written_o (cell_written_o),
    .written_addr_o (written_addr_o),
    .did_scroll_o   (did_scroll_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // move the cursor to the start of the next row, scrolling on the last row
  task automatic advance_row(output logic scrolled);
    int i;
    col_model = '0;
    scrolled  = 1'b0;
    if (int'(row_model) == ROWS - 1) begin
      for (i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
      for (i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = {attr_model, BLANK_GLYPH};
      scrolled = 1'b1;
      scroll_count++;
    end else begin
      row_model = row_model + 1'b1;
    end
  endtask

  // expected result of one character item
  task automatic predict_cursor_step(input logic [7:0] code);
    res_t r;
    int   addr;
    logic scrolled;
    r = '0;
    if (code == NEWLINE_CODE) begin
      newline_count++;
      advance_row(scrolled);
      r.did_scroll = scrolled;
    end else begin
      glyph_count++;
      addr = int'(row_model) * COLUMNS + int'(col_model);
      screen_model[addr] = {attr_model, code};
      r.cell_written = 1'b1;
      r.written_addr = addr[POS_W-1:0];
      if (int'(col_model) == COLUMNS - 1) begin
        // glyph in the last column wraps like a newline
        wrap_count++;
        advance_row(scrolled);
        r.did_scroll = scrolled;
      end else begin
        col_model = col_model + 1'b1;
      end
    end
    addr = int'(row_model) * COLUMNS + int'(col_model);
    r.cursor_pos = addr[POS_W-1:0];
    cursor_results.push_back(r);
  endtask

  task automatic check_field(input string label, input logic [POS_W-1:0] want,
                             input logic [POS_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
      errors++;
    end
  endtask

  // queue a chunk of characters and widen the cycle budget to match
  task automatic queue_chars(input logic [7:0] codes[$]);
    int nl, gl;
    nl = 0;
    gl = 0;
    foreach (codes[i]) begin
      char_q.push_back(codes[i]);
      if (codes[i] == NEWLINE_CODE) nl++;
      else gl++;
    end
    cycle_limit += 4 * (longint'(codes.size()) * 40 +
                        longint'(nl + gl / (COLUMNS - 1) + 2) * SCROLL_CYCLES);
  endtask

  // random text: mostly lines of random length ended by a newline, some noise
  task automatic add_random_text(input int n_items);
    logic [7:0] codes[$];
    logic [7:0] c;
    int         kind, len, k;
    while (codes.size() < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) len = $urandom_range(0, 30);
      else if (kind < 75) len = $urandom_range(COLUMNS - 4, COLUMNS + 4);
      else if (kind < 85) len = $urandom_range(2 * COLUMNS - 10, 2 * COLUMNS + 10);
      else if (kind < 93) len = 0;
      else len = -1;
      if (len >= 0) begin
        for (k = 0; k < len; k++) begin
          do c = 8'($urandom_range(0, 255)); while (c == NEWLINE_CODE);
          codes.push_back(c);
        end
        codes.push_back(NEWLINE_CODE);
      end else begin
        // noise: raw bytes with frequent newlines and no line structure
        len = $urandom_range(10, 30);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 2) == 0) c = NEWLINE_CODE;
          else c = 8'($urandom_range(0, 255));
          codes.push_back(c);
        end
      end
    end
    queue_chars(codes);
  endtask

  task automatic wait_drained();
    while (char_q.size() != 0 || took || cursor_results.size() != 0) @(posedge clk_i);
  endtask

  // attribute write while the block is idle, after any scroll has finished
  task automatic write_attribute(input logic [7:0] value);
    wait_drained();
    repeat (SCROLL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    attr_model = value;
    attr_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cycle_limit += 4 * (SCROLL_CYCLES + 100);
  endtask

  // sender: acceptance and prediction at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      predict_cursor_step(char_code_i);
      took = 1'b1;
    end
  end

  // sender: drive the next item at the falling edge
  always @(negedge clk_i) begin
    if (took) begin
      void'(char_q.pop_front());
      took = 1'b0;
    end
    if (send_calm > 0) send_calm--;
    else if (!no_idle && $urandom_range(0, 99) == 0) send_calm = $urandom_range(40, 160);
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (send_gap > 0) begin
      send_gap--;
      push <= 1'b0;
    end else if (char_q.size() == 0) begin
      push <= 1'b0;
    end else if (!no_idle && send_calm == 0 && $urandom_range(0, 6) == 0) begin
      send_gap = $urandom_range(1, 18) - 1;
      push <= 1'b0;
    end else begin
      push        <= 1'b1;
      char_code_i <= char_q[0];
    end
  end

  // receiver: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      if (cursor_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual cursor_pos %0d",
                 $time, cursor_pos_o);
        errors++;
      end else begin
        want = cursor_results.pop_front();
        check_field("cursor_pos", want.cursor_pos, cursor_pos_o);
        check_field("cell_written", POS_W'(want.cell_written), POS_W'(cell_written_o));
        check_field("written_addr", want.written_addr, written_addr_o);
        check_field("did_scroll", POS_W'(want.did_scroll), POS_W'(did_scroll_o));
      end
    end
  end

  // receiver: pop with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (pop_calm > 0) pop_calm--;
    else if (!no_idle && $urandom_range(0, 99) == 0) pop_calm = $urandom_range(40, 160);
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      pop <= 1'b0;
    end else if (!hold_done && results_seen >= 300) begin
      // long hold-off so the block fills up and raises full
      hold_done = 1'b1;
      hold_cnt  = HOLD_CYCLES - 1;
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else if (!no_idle && pop_calm == 0 && $urandom_range(0, 6) == 0) begin
      pop_gap = $urandom_range(1, 18) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // cycle budget
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, cursor_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus phases
  initial begin
    logic [7:0] directed[$];
    int         i;
    rst_ni      = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    char_code_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    errors      = 0;
    cycle_count = 0;
    // reset, clearing pass and the long hold-off
    cycle_limit = 4 * (CELLS + 3000 + HOLD_CYCLES);
    for (i = 0; i < CELLS; i++) screen_model[i] = {RESET_ATTR, BLANK_GLYPH};
    col_model  = '0;
    row_model  = '0;
    attr_model = RESET_ATTR;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extreme glyph codes, a newline from row 0, then down to the last row
    // and a newline there to force a scroll
    directed = '{8'h00, 8'hff, 8'h0b, 8'h09, BLANK_GLYPH, NEWLINE_CODE};
    for (i = 0; i < ROWS - 1; i++) directed.push_back(NEWLINE_CODE);
    directed.push_back(8'h7e);
    queue_chars(directed);

    write_attribute(8'h00);
    add_random_text(350);
    write_attribute(8'hff);
    add_random_text(350);
    write_attribute(8'(($urandom_range(0, 255))));
    add_random_text(350);
    write_attribute(8'ha5);
    add_random_text(350);
    write_attribute(8'h5a);

    // last stretch with both sides always ready
    no_idle = 1'b1;
    add_random_text(250);

    wait_drained();
    repeat (SCROLL_CYCLES) @(posedge clk_i);

    $display("covered %0d glyphs, %0d newlines, %0d last-column wraps, %0d scrolls",
             glyph_count, newline_count, wrap_count, scroll_count);
    $display("%0d attribute writes, %0d results checked, %0d errors",
             attr_writes, results_seen, errors);
    if (errors == 0 && cursor_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
